// ----- hw/rtl/lpc_pkg.sv -----
// shared constants, types and the palette function for the label colorizer
package lpc_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // color source for one item
  localparam logic [1:0] MODE_BLACK   = 2'd0;
  localparam logic [1:0] MODE_PALETTE = 2'd1;
  localparam logic [1:0] MODE_HUE     = 2'd2;

  localparam logic [31:0] PALETTE_LIMIT = 32'd21;
  localparam logic [31:0] GOLDEN_STEP   = 32'h9E37_79B9;

  // 255 * s * v in thousandths, and the rounded constant bytes
  localparam logic [33:0] SV_MILLI = 34'd169575;
  localparam logic [7:0]  V_BYTE   = 8'd242;
  localparam logic [7:0]  P_BYTE   = 8'd73;

  // (242.25 + 0.5) and (72.675 + 0.5) in units of 1/(1000*65536)
  localparam logic [34:0] Q_NUMER = 35'd15908864000;
  localparam logic [34:0] T_NUMER = 35'd4795596800;

  // floor(y / 1000) = (y * DIV1000_RECIP) >> DIV1000_SHIFT for y below 2^18
  localparam logic [36:0] DIV1000_RECIP = 37'd268436;
  localparam int          DIV1000_SHIFT = 28;

  // cycles from the accepting edge to the edge that takes the result
  localparam int PIPE_LATENCY = 7;

  // sector codes of the hue circle
  localparam logic [2:0] SECTOR_0 = 3'd0;
  localparam logic [2:0] SECTOR_1 = 3'd1;
  localparam logic [2:0] SECTOR_2 = 3'd2;
  localparam logic [2:0] SECTOR_3 = 3'd3;
  localparam logic [2:0] SECTOR_4 = 3'd4;

  // bit interleave: id bit 3i to red bit 7-i, 3i+1 to green, 3i+2 to blue
  function automatic rgb_t palette_color(input logic [31:0] id);
    rgb_t c;
    for (int i = 0; i < 8; i++) begin
      c.red[7-i]   = id[3*i];
      c.green[7-i] = id[3*i+1];
      c.blue[7-i]  = id[3*i+2];
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/label_palette_colorizer.sv -----
// label colorizer: label id to blue, green, red overlay bytes, seven-stage pipeline
//
// usage:
//   an item (label_id, end_of_frame) is taken at each rising edge where start
//   is high and busy is low. busy is low except during reset, so one item can
//   enter on every clock.
//   each item gives one result on blue, green, red and frame_done, marked by
//   done for exactly one cycle. throughput is one item per clock outside reset;
//   each item passes through seven register stages: input, golden-ratio multiply,
//   hue times six, fraction times the saturation span, numerator and scale,
//   divide by 1000 through a reciprocal multiply, and the output register.
//   labels of zero or below give black, labels 1 to 20 the interleaved palette,
//   larger labels the golden-ratio hue walk.
//   reset clears the stage valid bits, so nothing in flight comes out after it.
//   the receiver cannot stall: results leave in order, one per accepted item,
//   and must be taken in the cycle that done is high.
module label_palette_colorizer
  import lpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] label_id,
  input  logic               end_of_frame,
  output logic               done,
  output logic [7:0]         blue,
  output logic [7:0]         green,
  output logic [7:0]         red,
  output logic               frame_done
);

  logic v0, v1, v2, v3, v4, v5;

  // stage 0: input register
  logic [31:0] id0;
  logic        eof0;

  // stage 1: hue word and class
  logic [31:0] h1;
  logic [1:0]  mode1;
  rgb_t        pal1;
  logic        eof1;

  // stage 2: sector and fraction
  logic [2:0]  sector2;
  logic [15:0] f2;
  logic [1:0]  mode2;
  rgb_t        pal2;
  logic        eof2;

  // stage 3: fraction times span
  logic [33:0] x3;
  logic [2:0]  sector3;
  logic [1:0]  mode3;
  rgb_t        pal3;
  logic        eof3;

  // stage 4: numerators scaled by 1/65536
  logic [17:0] yq4, yt4;
  logic [2:0]  sector4;
  logic [1:0]  mode4;
  rgb_t        pal4;
  logic        eof4;

  // stage 5: rounded bytes
  logic [7:0]  q5, t5;
  logic [2:0]  sector5;
  logic [1:0]  mode5;
  rgb_t        pal5;
  logic        eof5;

  logic        accept;
  logic [31:0] h_prod;
  logic [1:0]  mode_next;
  logic [34:0] p6;
  logic [33:0] x_prod;
  logic [34:0] q_num, t_num;
  logic [36:0] q_prod, t_prod;
  rgb_t        hue_rgb, color_next;

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      done <= 1'b0;
    end else begin
      v0 <= accept;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      done <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      id0  <= label_id;
      eof0 <= end_of_frame;
    end
  end

  assign h_prod = id0 * GOLDEN_STEP;

  always_comb begin
    if (id0[31] || id0 == 32'd0) begin
      mode_next = MODE_BLACK;
    end else if (id0 < PALETTE_LIMIT) begin
      mode_next = MODE_PALETTE;
    end else begin
      mode_next = MODE_HUE;
    end
  end

  always_ff @(posedge clk) begin
    h1    <= h_prod;
    mode1 <= mode_next;
    pal1  <= palette_color(id0);
    eof1  <= eof0;
  end

  // hue times six as 4h + 2h
  assign p6 = {1'b0, h1, 2'b00} + {2'b00, h1, 1'b0};

  always_ff @(posedge clk) begin
    sector2 <= p6[34:32];
    f2      <= p6[31:16];
    mode2   <= mode1;
    pal2    <= pal1;
    eof2    <= eof1;
  end

  assign x_prod = {18'd0, f2} * SV_MILLI;

  always_ff @(posedge clk) begin
    x3      <= x_prod;
    sector3 <= sector2;
    mode3   <= mode2;
    pal3    <= pal2;
    eof3    <= eof2;
  end

  assign q_num = Q_NUMER - {1'b0, x3};
  assign t_num = T_NUMER + {1'b0, x3};

  always_ff @(posedge clk) begin
    yq4     <= q_num[33:16];
    yt4     <= t_num[33:16];
    sector4 <= sector3;
    mode4   <= mode3;
    pal4    <= pal3;
    eof4    <= eof3;
  end

  assign q_prod = {19'd0, yq4} * DIV1000_RECIP;
  assign t_prod = {19'd0, yt4} * DIV1000_RECIP;

  always_ff @(posedge clk) begin
    q5      <= q_prod[DIV1000_SHIFT +: 8];
    t5      <= t_prod[DIV1000_SHIFT +: 8];
    sector5 <= sector4;
    mode5   <= mode4;
    pal5    <= pal4;
    eof5    <= eof4;
  end

  always_comb begin
    case (sector5)
      SECTOR_0: hue_rgb = '{red: V_BYTE, green: t5,     blue: P_BYTE};
      SECTOR_1: hue_rgb = '{red: q5,     green: V_BYTE, blue: P_BYTE};
      SECTOR_2: hue_rgb = '{red: P_BYTE, green: V_BYTE, blue: t5};
      SECTOR_3: hue_rgb = '{red: P_BYTE, green: q5,     blue: V_BYTE};
      SECTOR_4: hue_rgb = '{red: t5,     green: P_BYTE, blue: V_BYTE};
      default:  hue_rgb = '{red: V_BYTE, green: P_BYTE, blue: q5};
    endcase
  end

  always_comb begin
    case (mode5)
      MODE_PALETTE: color_next = pal5;
      MODE_HUE:     color_next = hue_rgb;
      default:      color_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    red        <= color_next.red;
    green      <= color_next.green;
    blue       <= color_next.blue;
    frame_done <= eof5;
  end

endmodule

// ----- hw/rtl/lpc_checker.sv -----
// port-level checker for the label colorizer, bound to the top level
module lpc_checker
  import lpc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] label_id,
  input logic               end_of_frame,
  input logic               done,
  input logic [7:0]         blue,
  input logic [7:0]         green,
  input logic [7:0]         red,
  input logic               frame_done
);

  // every accepted item comes out after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##PIPE_LATENCY done)
    else $error("accepted item produced no result");

  // no result without an item accepted the latency before
  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result without an accepted item");

  a_frame_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> frame_done == $past(end_of_frame, PIPE_LATENCY))
    else $error("frame_done does not match the item's end_of_frame");

  // labels of zero or below give black
  a_black: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (label_id[31] || label_id == 32'sd0)) |->
      ##PIPE_LATENCY (done && blue == 8'd0 && green == 8'd0 && red == 8'd0))
    else $error("non-positive label did not give black");

endmodule

bind label_palette_colorizer lpc_checker u_lpc_checker (.*);
